// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: src/slfa_pkg.sv
// ----------------------------------------------------------------------------
// slfa_pkg
// Widths, codes and shared types of the slice free list allocator
// ----------------------------------------------------------------------------
package slfa_pkg;

    // default pool depth
    localparam int MAX_SLOTS_DEF = 2048;

    // field widths
    localparam int OP_W   = 2;
    localparam int ID_W   = 11;
    localparam int CAP_W  = 12;
    localparam int CNT_W  = 12;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    // register index (paddr[2])
    localparam logic REG_SLOT_CAPACITY = 1'b0;

    // control from the request stage to the free stack
    typedef struct packed {
        logic             load;
        logic             pop;
        logic             push;
        logic [ID_W-1:0]  push_id;
        logic [CAP_W-1:0] cap;
    } stk_ctrl_t;

endpackage

// File: src/slfa_marks.sv
// ----------------------------------------------------------------------------
// slfa_marks
// Used-mark memory: one write and one registered read per cycle, with the
// write data forwarded when both hit the same slot in the same cycle
// ----------------------------------------------------------------------------
module slfa_marks #(
    parameter  int MAX_SLOTS = slfa_pkg::MAX_SLOTS_DEF,
    localparam int IDX_W     = $clog2(MAX_SLOTS)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic             wr_data,
    output logic             rd_data
);

    logic mem [MAX_SLOTS];
    logic rd_data_reg;

    // mark storage with write-to-read forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/slfa_stack.sv
// ----------------------------------------------------------------------------
// slfa_stack
// LIFO free stack: top entry in a register, the rest in a memory. Entries
// below the low-water mark still hold their refill value and are produced
// arithmetically instead of being written on a capacity load
// ----------------------------------------------------------------------------
module slfa_stack #(
    parameter  int MAX_SLOTS = slfa_pkg::MAX_SLOTS_DEF,
    localparam int DEPTH_W   = $clog2(MAX_SLOTS + 1),
    localparam int IDX_W     = $clog2(MAX_SLOTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  slfa_pkg::stk_ctrl_t ctrl,
    output logic [DEPTH_W-1:0]  depth,
    output logic [IDX_W-1:0]    top,
    output logic [DEPTH_W-1:0]  issued
);

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] low_reg, low_next;
    logic [DEPTH_W-1:0] cap_reg, cap_next;
    logic               top_rd_reg, top_rd_next;
    logic               rd_fresh_reg, rd_fresh_next;
    logic [IDX_W-1:0]   top_reg, top_next;
    logic [IDX_W-1:0]   fresh_val_reg, fresh_val_next;
    logic [IDX_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]   top_val;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [DEPTH_W-1:0] cap_in;
    logic               pop_en;
    logic               wr_en;

    logic [IDX_W-1:0] mem [MAX_SLOTS];

    // current top: register after a push or load, memory or refill value after a pop
    always_comb
    begin
        if (!top_rd_reg)
        begin
            top_val = top_reg;
        end
        else if (rd_fresh_reg)
        begin
            top_val = fresh_val_reg;
        end
        else
        begin
            top_val = rd_data_reg;
        end
    end

    // next state of the stack
    always_comb
    begin
        cap_in         = DEPTH_W'(ctrl.cap);
        depth_next     = depth_reg;
        low_next       = low_reg;
        cap_next       = cap_reg;
        top_rd_next    = top_rd_reg;
        rd_fresh_next  = rd_fresh_reg;
        top_next       = top_reg;
        fresh_val_next = fresh_val_reg;
        rd_addr        = IDX_W'(depth_reg - DEPTH_W'(2));
        wr_addr        = IDX_W'(depth_reg - DEPTH_W'(1));
        pop_en         = 1'b0;
        wr_en          = 1'b0;
        if (ctrl.load)
        begin
            depth_next    = cap_in;
            low_next      = cap_in;
            cap_next      = cap_in;
            top_next      = '0;
            top_rd_next   = 1'b0;
            rd_fresh_next = 1'b0;
        end
        else if (ctrl.pop)
        begin
            pop_en         = 1'b1;
            depth_next     = depth_reg - DEPTH_W'(1);
            top_rd_next    = 1'b1;
            rd_fresh_next  = (depth_reg == low_reg);
            fresh_val_next = IDX_W'(cap_reg + DEPTH_W'(1) - depth_reg);
            if (depth_reg == low_reg)
            begin
                low_next = depth_reg - DEPTH_W'(1);
            end
        end
        else if (ctrl.push)
        begin
            depth_next  = depth_reg + DEPTH_W'(1);
            top_next    = IDX_W'(ctrl.push_id);
            top_rd_next = 1'b0;
            wr_en       = (depth_reg != '0);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= '0;
            low_reg      <= '0;
            cap_reg      <= '0;
            top_rd_reg   <= 1'b0;
            rd_fresh_reg <= 1'b0;
        end
        else
        begin
            depth_reg    <= depth_next;
            low_reg      <= low_next;
            cap_reg      <= cap_next;
            top_rd_reg   <= top_rd_next;
            rd_fresh_reg <= rd_fresh_next;
        end
    end

    // stack memory and payload registers
    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        fresh_val_reg <= fresh_val_next;
        if (wr_en)
        begin
            mem[wr_addr] <= top_val;
        end
        if (pop_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign depth  = depth_reg;
    assign top    = top_val;
    assign issued = cap_reg - low_reg;

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_low_above_depth, low_reg > depth_reg, "low-water mark above stack depth")
    `ASSERT_NEVER(a_pop_when_empty, ctrl.pop && (depth_reg == '0), "pop of an empty stack")
    `ASSERT_NEVER(a_depth_above_cap, depth_reg > cap_reg, "stack deeper than the pool")

endmodule

// File: src/slice_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// slice_free_list_allocator_top
// Slot allocator over a LIFO free stack with per-slot used marks
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall) carries op and slot_id: allocate,
// release or query. Response channel (rsp_valid / rsp_stall) returns one
// transaction per request: ok, granted_slot and used_count after the request.
// A request accepted at one clock edge is held in the input register, then
// handled there once the response register is free, which registers its
// response: one request per cycle sustained while rsp_stall stays low. This
// suits the registered read of the used-mark memory, issued at acceptance.
// The APB port holds slot_capacity at address 0; writing it loads a full
// free stack at once (no sweep) and empties the pool. Write it only while
// no request is in flight.
// After reset the capacity is 0: every allocate fails, nothing is used.
// While rsp_stall holds a response, one more request is taken into the
// input register, then req_stall rises until the response is taken.
// ----------------------------------------------------------------------------
module slice_free_list_allocator_top #(
    parameter  int MAX_SLOTS = slfa_pkg::MAX_SLOTS_DEF,
    localparam int DEPTH_W   = $clog2(MAX_SLOTS + 1),
    localparam int IDX_W     = $clog2(MAX_SLOTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slfa_pkg::ADDR_W-1:0]   paddr,
    input  logic [slfa_pkg::DATA_W-1:0]   pwdata,
    output logic [slfa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [slfa_pkg::OP_W-1:0]     op,
    input  logic [slfa_pkg::ID_W-1:0]     slot_id,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          ok,
    output logic [slfa_pkg::ID_W-1:0]     granted_slot,
    output logic [slfa_pkg::CNT_W-1:0]    used_count
);

    localparam int CMP_W = (DEPTH_W > slfa_pkg::ID_W) ? DEPTH_W : slfa_pkg::ID_W;

    // request stage
    logic                        in_vld_reg;
    logic [slfa_pkg::OP_W-1:0]   op_reg;
    logic [slfa_pkg::ID_W-1:0]   id_reg;
    logic                        req_acc;
    logic                        adv;

    // response stage
    logic                        out_vld_reg;
    logic                        ok_reg, ok_next;
    logic [slfa_pkg::ID_W-1:0]   granted_reg, granted_next;
    logic [slfa_pkg::CNT_W-1:0]  used_count_reg;

    // pool state
    logic [DEPTH_W-1:0]          in_use_reg, in_use_next;
    logic [slfa_pkg::CAP_W-1:0]  cap_raw_reg;
    logic [DEPTH_W-1:0]          cap_eff_reg;

    // configuration decode
    logic                        cfg_wr;
    logic [slfa_pkg::CAP_W-1:0]  wr_cap;
    logic                        cap_fits;
    logic [slfa_pkg::CAP_W-1:0]  cap_eff_wr;

    // submodule links
    slfa_pkg::stk_ctrl_t         stk_ctrl;
    logic [DEPTH_W-1:0]          stk_depth;
    logic [IDX_W-1:0]            stk_top;
    logic [DEPTH_W-1:0]          stk_issued;
    logic                        mk_rd_data;
    logic                        mk_wr_en;
    logic [IDX_W-1:0]            mk_wr_addr;
    logic                        mk_wr_data;
    logic                        slot_used;

    // handshake
    assign adv       = in_vld_reg && (!out_vld_reg || !rsp_stall);
    assign req_stall = in_vld_reg && !adv;
    assign req_acc   = req_valid && !req_stall;

    // configuration write and readback
    assign cfg_wr     = psel && penable && pwrite && (paddr[2] == slfa_pkg::REG_SLOT_CAPACITY);
    assign wr_cap     = pwdata[slfa_pkg::CAP_W-1:0];
    assign cap_fits   = (wr_cap != '0) && (32'(wr_cap) <= 32'(MAX_SLOTS));
    assign cap_eff_wr = cap_fits ? wr_cap : '0;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == slfa_pkg::REG_SLOT_CAPACITY) ?
                        slfa_pkg::DATA_W'(cap_raw_reg) : '0;

    // a slot counts as used only if it has been handed out since the last load
    assign slot_used = (CMP_W'(id_reg) < CMP_W'(stk_issued)) && mk_rd_data;

    // request decode
    always_comb
    begin
        stk_ctrl         = '0;
        stk_ctrl.load    = cfg_wr;
        stk_ctrl.cap     = cap_eff_wr;
        stk_ctrl.push_id = id_reg;
        ok_next          = 1'b0;
        granted_next     = '0;
        in_use_next      = in_use_reg;
        mk_wr_en         = 1'b0;
        mk_wr_addr       = stk_top;
        mk_wr_data       = 1'b0;
        if (cfg_wr)
        begin
            in_use_next = '0;
        end
        else if (adv)
        begin
            unique case (op_reg)
                slfa_pkg::OP_ALLOC:
                begin
                    if (stk_depth != '0)
                    begin
                        stk_ctrl.pop = 1'b1;
                        ok_next      = 1'b1;
                        granted_next = slfa_pkg::ID_W'(stk_top);
                        in_use_next  = in_use_reg + DEPTH_W'(1);
                        mk_wr_en     = 1'b1;
                        mk_wr_data   = 1'b1;
                    end
                end
                slfa_pkg::OP_RELEASE:
                begin
                    if (slot_used && (stk_depth < DEPTH_W'(MAX_SLOTS)))
                    begin
                        stk_ctrl.push = 1'b1;
                        ok_next       = 1'b1;
                        mk_wr_en      = 1'b1;
                        mk_wr_addr    = IDX_W'(id_reg);
                        if (in_use_reg != '0)
                        begin
                            in_use_next = in_use_reg - DEPTH_W'(1);
                        end
                    end
                end
                slfa_pkg::OP_QUERY:
                begin
                    ok_next = slot_used;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            in_use_reg  <= '0;
            cap_raw_reg <= '0;
            cap_eff_reg <= '0;
        end
        else
        begin
            if (req_acc)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_vld_reg <= 1'b0;
            end
            if (adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_vld_reg <= 1'b0;
            end
            in_use_reg <= in_use_next;
            if (cfg_wr)
            begin
                cap_raw_reg <= wr_cap;
                cap_eff_reg <= DEPTH_W'(cap_eff_wr);
            end
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            op_reg <= op;
            id_reg <= slot_id;
        end
        if (adv)
        begin
            ok_reg         <= ok_next;
            granted_reg    <= granted_next;
            used_count_reg <= slfa_pkg::CNT_W'(in_use_next);
        end
    end

    assign rsp_valid    = out_vld_reg;
    assign ok           = ok_reg;
    assign granted_slot = granted_reg;
    assign used_count   = used_count_reg;

    // used-mark memory, read as the request is accepted
    slfa_marks #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_marks (
        .clk     (clk),
        .rd_en   (req_acc),
        .rd_addr (IDX_W'(slot_id)),
        .wr_en   (mk_wr_en),
        .wr_addr (mk_wr_addr),
        .wr_data (mk_wr_data),
        .rd_data (mk_rd_data)
    );

    // free stack
    slfa_stack #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (stk_ctrl),
        .depth  (stk_depth),
        .top    (stk_top),
        .issued (stk_issued)
    );

    `include "assert_macros.svh"

    `ASSERT_AT_CLK(a_grant_count, adv && !cfg_wr && (op_reg == slfa_pkg::OP_ALLOC) && (stk_depth != '0) |=> in_use_reg == $past(in_use_reg) + DEPTH_W'(1), "granted allocate did not raise the in-use count")
    `ASSERT_NEVER(a_slot_conservation, (DEPTH_W+1)'(in_use_reg) + (DEPTH_W+1)'(stk_depth) != (DEPTH_W+1)'(cap_eff_reg), "used plus free slots differ from capacity")

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slice free list allocator: a directed table,
// then random request phases at several pool capacities, each response
// checked field by field against the table or an in-bench model of the free stack
// ----------------------------------------------------------------------------
module tb;

    // no-operation code and the capacity register address
    localparam logic [slfa_pkg::OP_W-1:0]   OP_NONE  = 2'd3;
    localparam logic [slfa_pkg::ADDR_W-1:0] CAP_ADDR = {slfa_pkg::REG_SLOT_CAPACITY, 2'b00};

    localparam int POOL_MAX    = slfa_pkg::MAX_SLOTS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 38;
    localparam int FILL_ITEMS  = 400;
    // four phases per idling mode; the last phase leans on allocates from the largest pool
    localparam int PHASE_CAP [PHASES] = '{1, 5, 4095, 16, 2, 64, 0, 7, 33, 2047, 3, 2048};

    typedef struct packed {
        logic                       ok;
        logic [slfa_pkg::ID_W-1:0]  slot;
        logic [slfa_pkg::CNT_W-1:0] count;
    } alloc_rsp_t;

    typedef enum logic {ROW_WRITE, ROW_REQ} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [31:0]               cap_word;
        logic [slfa_pkg::OP_W-1:0] op;
        logic [slfa_pkg::ID_W-1:0] id;
        bit                        typed;
        alloc_rsp_t                want;
    } plan_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [slfa_pkg::ADDR_W-1:0]   paddr;
    logic [slfa_pkg::DATA_W-1:0]   pwdata;
    logic [slfa_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          req_valid;
    logic                          req_stall;
    logic [slfa_pkg::OP_W-1:0]     op;
    logic [slfa_pkg::ID_W-1:0]     slot_id;
    logic                          rsp_valid;
    logic                          rsp_stall;
    logic                          ok;
    logic [slfa_pkg::ID_W-1:0]     granted_slot;
    logic [slfa_pkg::CNT_W-1:0]    used_count;

    // free stack model state
    logic [slfa_pkg::ID_W-1:0]     free_ids [POOL_MAX];
    logic                          slot_used [POOL_MAX];
    int                            stack_top;
    int                            used_total;
    int                            pool_cap;

    alloc_rsp_t                    expect_q [$];
    int                            mismatch_count = 0;
    int                            quiet_cycles   = 0;
    int unsigned                   send_idle_pct;
    int unsigned                   rsp_stall_pct;

    slice_free_list_allocator_top #(
        .MAX_SLOTS (POOL_MAX)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .op           (op),
        .slot_id      (slot_id),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .ok           (ok),
        .granted_slot (granted_slot),
        .used_count   (used_count)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // capacity write: empty the pool, refill ids descending so 0 pops first
    function automatic void pool_load(input logic [31:0] word);
        int cap;
        int i;
        cap = int'(word[slfa_pkg::CAP_W-1:0]);
        for (i = 0; i < POOL_MAX; i++)
        begin
            free_ids[i]  = '0;
            slot_used[i] = 1'b0;
        end
        stack_top  = 0;
        used_total = 0;
        pool_cap   = 0;
        // zero or oversize capacity leaves the pool empty
        if (cap != 0 && cap <= POOL_MAX)
        begin
            pool_cap = cap;
            for (i = 0; i < cap; i++)
                free_ids[i] = slfa_pkg::ID_W'(cap - 1 - i);
            stack_top = cap;
        end
    endfunction

    // expected response for one request transaction, updating the model
    function automatic alloc_rsp_t allocator_predict(input logic [slfa_pkg::OP_W-1:0] o,
                                                     input logic [slfa_pkg::ID_W-1:0] id);
        alloc_rsp_t                r;
        logic [slfa_pkg::ID_W-1:0] top;
        r = '0;
        if (o == slfa_pkg::OP_ALLOC)
        begin
            if (stack_top > 0)
            begin
                stack_top--;
                top            = free_ids[stack_top];
                slot_used[top] = 1'b1;
                used_total++;
                r.ok   = 1'b1;
                r.slot = top;
            end
        end
        else if (o == slfa_pkg::OP_RELEASE)
        begin
            // only a used, in-range slot goes back on the stack
            if (int'(id) < pool_cap && slot_used[id] && stack_top < POOL_MAX)
            begin
                slot_used[id] = 1'b0;
                if (used_total > 0)
                    used_total--;
                free_ids[stack_top] = id;
                stack_top++;
                r.ok = 1'b1;
            end
        end
        else if (o == slfa_pkg::OP_QUERY)
        begin
            r.ok = (int'(id) < pool_cap) && slot_used[id];
        end
        r.count = slfa_pkg::CNT_W'(used_total);
        return r;
    endfunction

    // a slot that is likely in use, for well-formed releases
    function automatic logic [slfa_pkg::ID_W-1:0] pick_used_id();
        logic [slfa_pkg::ID_W-1:0] cand;
        int                        tries;
        cand = slfa_pkg::ID_W'($urandom);
        if (pool_cap == 0)
            return cand;
        for (tries = 0; tries < 16; tries++)
        begin
            cand = slfa_pkg::ID_W'($urandom_range(pool_cap - 1));
            if (slot_used[cand])
                break;
        end
        return cand;
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("tb: %s", msg);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 34;
                rsp_stall_pct = 71;
            end
            1:
            begin
                send_idle_pct = 71;
                rsp_stall_pct = 34;
            end
            default:
            begin
                send_idle_pct = 0;
                rsp_stall_pct = 0;
            end
        endcase
    endtask

    // drive one request transaction and queue its expected response
    task automatic send_req(input logic [slfa_pkg::OP_W-1:0] o,
                            input logic [slfa_pkg::ID_W-1:0] id,
                            input bit typed, input alloc_rsp_t want);
        alloc_rsp_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= o;
        slot_id   <= id;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        got = allocator_predict(o, id);
        expect_q.insert(expect_q.size(), typed ? want : got);
    endtask

    // hold off requests until every response is back
    task automatic drain_responses();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expect_q.size() != 0);
    endtask

    // apb write of the capacity register while the block is idle
    task automatic write_capacity(input logic [31:0] word);
        drain_responses();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_load(word);
    endtask

    function automatic plan_row_t cap_row(input logic [31:0] word);
        plan_row_t r;
        r.kind     = ROW_WRITE;
        r.cap_word = word;
        r.op       = '0;
        r.id       = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic plan_row_t req_row(input logic [slfa_pkg::OP_W-1:0] o, input int id,
                                          input bit typed, input bit k,
                                          input int slot, input int count);
        plan_row_t r;
        r.kind       = ROW_REQ;
        r.cap_word   = '0;
        r.op         = o;
        r.id         = slfa_pkg::ID_W'(id);
        r.typed      = typed;
        r.want.ok    = k;
        r.want.slot  = slfa_pkg::ID_W'(slot);
        r.want.count = slfa_pkg::CNT_W'(count);
        return r;
    endfunction

    // response checker and random receiver stall
    always @(posedge clk)
    begin
        alloc_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expect_q.size() == 0)
                    report_error($sformatf("response with none pending: ok %0d slot %0d count %0d",
                                           ok, granted_slot, used_count));
                else
                begin
                    want = expect_q.pop_front();
                    if (ok !== want.ok)
                        report_error($sformatf("ok: expected %0d, got %0d", want.ok, ok));
                    if (granted_slot !== want.slot)
                        report_error($sformatf("granted_slot: expected %0d, got %0d",
                                               want.slot, granted_slot));
                    if (used_count !== want.count)
                        report_error($sformatf("used_count: expected %0d, got %0d",
                                               want.count, used_count));
                end
            end
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        plan_row_t                 plan [$];
        logic [slfa_pkg::OP_W-1:0] r_op;
        logic [slfa_pkg::ID_W-1:0] r_id;
        int                        roll;
        int                        items;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        op        = slfa_pkg::OP_ALLOC;
        slot_id   = '0;
        rsp_stall = 1'b0;
        pool_load('0);
        set_idle(0);

        // after reset: empty pool, nothing used
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 0, 0, 0));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_RELEASE, 0,    1, 0, 0, 0));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_QUERY,   2047, 1, 0, 0, 0));
        plan.insert(plan.size(), req_row(OP_NONE,              2047, 1, 0, 0, 0));
        // single slot pool: exhaust, out-of-range, double release
        plan.insert(plan.size(), cap_row(32'd1));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 1, 0, 1));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   2047, 1, 0, 0, 1));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_QUERY,   0,    1, 1, 0, 1));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_QUERY,   1,    1, 0, 0, 1));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_RELEASE, 1,    1, 0, 0, 1));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_RELEASE, 0,    1, 1, 0, 0));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_RELEASE, 0,    1, 0, 0, 0));
        // largest pool: ascending ids, lifo reuse
        plan.insert(plan.size(), cap_row(32'd2048));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 1, 0, 1));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 1, 1, 2));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_QUERY,   2047, 1, 0, 0, 2));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_RELEASE, 1,    1, 1, 0, 1));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    0, 0, 0, 0));
        plan.insert(plan.size(), req_row(OP_NONE,              1234, 1, 0, 0, 2));
        // oversize and zero capacity leave an empty pool
        plan.insert(plan.size(), cap_row(32'd4095));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 0, 0, 0));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_QUERY,   0,    1, 0, 0, 0));
        plan.insert(plan.size(), cap_row(32'd0));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_QUERY,   0,    1, 0, 0, 0));
        plan.insert(plan.size(), cap_row(32'd2049));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 0, 0, 0));
        // upper write bits are ignored: capacity 3
        plan.insert(plan.size(), cap_row(32'hFFFF_F003));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 1, 0, 1));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 1, 1, 2));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 1, 2, 3));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_ALLOC,   0,    1, 0, 0, 3));
        plan.insert(plan.size(), req_row(slfa_pkg::OP_RELEASE, 2047, 1, 0, 0, 3));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_WRITE)
                write_capacity(plan[k].cap_word);
            else
                send_req(plan[k].op, plan[k].id, plan[k].typed, plan[k].want);
        end

        // random phases, mostly well-formed alloc/release traffic
        for (int p = 0; p < PHASES; p++)
        begin
            set_idle(p / 4);
            write_capacity(PHASE_CAP[p]);
            items = (PHASE_CAP[p] == POOL_MAX) ? FILL_ITEMS : PHASE_ITEMS;
            for (int n = 0; n < items; n++)
            begin
                if (n == items / 2)
                    drain_responses();
                r_id = slfa_pkg::ID_W'($urandom);
                roll = $urandom_range(99);
                if (PHASE_CAP[p] == POOL_MAX && roll < 92)
                    r_op = slfa_pkg::OP_ALLOC;
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 35)
                        r_op = slfa_pkg::OP_ALLOC;
                    else if (roll < 65)
                    begin
                        r_op = slfa_pkg::OP_RELEASE;
                        r_id = pick_used_id();
                    end
                    else if (roll < 75)
                        r_op = slfa_pkg::OP_RELEASE;
                    else if (roll < 85)
                    begin
                        r_op = slfa_pkg::OP_QUERY;
                        if (pool_cap != 0)
                            r_id = slfa_pkg::ID_W'($urandom_range(pool_cap - 1));
                    end
                    else if (roll < 93)
                        r_op = slfa_pkg::OP_QUERY;
                    else
                        r_op = OP_NONE;
                end
                send_req(r_op, r_id, 1'b0, '0);
            end
        end

        drain_responses();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && expect_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
